// ----- rtl/indexed_array_list_core_defines.svh -----
// Assertion helpers for the file that carries concurrent checks.
// Every check is sampled on the rising clock edge and is off while reset is low.
`ifndef INDEXED_ARRAY_LIST_CORE_DEFINES_SVH
`define INDEXED_ARRAY_LIST_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IAL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ial_pkg.sv -----
`timescale 1ns / 1ps

package ial_pkg;

    // Request codes carried in the input tuser.
    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_READ   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    // Result status carried in the output tuser.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_OUTSIDE = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_FINAL,
        S_FILL,
        S_RDWAIT,
        S_RESP
    } t_state;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    // One finished result as it leaves the sequencer.
    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0]        count;
        t_status                   status;
    } t_result;

endpackage

// ----- rtl/indexed_array_list_core.sv -----
`timescale 1ns / 1ps
// Bounded ordered list of signed 32-bit words held in one single-port-write,
// one-port-read memory of CAPACITY entries, with one result beat for every
// request beat. Requests are worked one at a time: append, clear, unused codes
// and rejected requests go straight to the result, a read waits for the
// memory's registered read data, an insert or a delete shifts the tail, and an
// insert at or past the end fills up to its position; the shift and fill loops
// move one entry per cycle through the memory's single write port.
// A result waits in an output register, so the next request is taken as soon
// as the previous one has been handed to that register. The memory needs no
// clearing after reset.
`include "indexed_array_list_core_defines.svh"

module indexed_array_list_core #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value [31:0], position [35:32], zero [39:36]
    input  logic [2:0]  s_tuser,   // operation [2:0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_value [31:0], count [36:32], zero [39:37]
    output logic [1:0]  m_tuser    // status [1:0]
);

    localparam int AW = $clog2(CAPACITY);

    logic                        w_wr_en;
    logic [AW-1:0]               w_wr_addr;
    logic [ial_pkg::VALUE_W-1:0] w_wr_data;
    logic                        w_rd_en;
    logic [AW-1:0]               w_rd_addr;
    logic [ial_pkg::VALUE_W-1:0] w_rd_data;
    logic                        w_res_valid;
    logic                        w_res_ready;
    ial_pkg::t_result            w_res;

    logic                        r_m_valid;
    ial_pkg::t_result            r_m_res;

    // Request sequencer.
    ial_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_tvalid),
        .o_req_ready (s_tready),
        .i_op        (s_tuser),
        .i_value     (s_tdata[31:0]),
        .i_position  (s_tdata[35:32]),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    // Entry storage.
    ial_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Output register: loads when empty or when its beat leaves this cycle.
    assign w_res_ready = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_m_res <= w_res;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {3'b000, r_m_res.count, r_m_res.read_value};
    assign m_tuser  = r_m_res.status;

    // A request is never accepted in the cycle right after an accepted one.
    `IAL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_tvalid && s_tready, !s_tready, "request accepted while the previous one was still in the sequencer")

    // Only a successful request may carry a nonzero read value.
    `IAL_ASSERT_SAME(a_zero_on_error, i_clk, i_rst_n, m_tvalid && (m_tuser != ial_pkg::ST_OK), m_tdata[31:0] == 32'd0, "rejected request returned a nonzero read value")

    // A result handed to the output register shows up as a beat next cycle.
    `IAL_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, w_res_valid && w_res_ready, m_tvalid, "result lost between sequencer and output register")

endmodule

// ----- rtl/ial_ram.sv -----
`timescale 1ns / 1ps

module ial_ram #(
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [AW-1:0]                   i_wr_addr,
    input  logic [ial_pkg::VALUE_W-1:0]     i_wr_data,
    input  logic                            i_rd_en,
    input  logic [AW-1:0]                   i_rd_addr,
    output logic [ial_pkg::VALUE_W-1:0]     o_rd_data
);

    logic [ial_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [ial_pkg::VALUE_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/ial_seq.sv -----
`timescale 1ns / 1ps

module ial_seq #(
    parameter int  CAPACITY = 16,
    localparam int AW       = $clog2(CAPACITY),
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request side.
    input  logic                                i_req_valid,
    output logic                                o_req_ready,
    input  logic [2:0]                          i_op,
    input  logic [ial_pkg::VALUE_W-1:0]         i_value,
    input  logic [ial_pkg::POS_W-1:0]           i_position,
    // Result side.
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output ial_pkg::t_result                    o_res,
    // Memory ports.
    output logic                                o_wr_en,
    output logic [AW-1:0]                       o_wr_addr,
    output logic [ial_pkg::VALUE_W-1:0]         o_wr_data,
    output logic                                o_rd_en,
    output logic [AW-1:0]                       o_rd_addr,
    input  logic [ial_pkg::VALUE_W-1:0]         i_rd_data
);

    // Compare width that holds the count, the capacity and any position.
    localparam int EW = (CW > ial_pkg::COUNT_W) ? CW : ial_pkg::COUNT_W;

    ial_pkg::t_state             r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [ial_pkg::VALUE_W-1:0] r_value, n_value;
    logic [AW-1:0]               r_pos, n_pos;
    logic [AW-1:0]               r_src, n_src;
    logic [AW-1:0]               r_dst, n_dst;
    logic [CW-1:0]               r_left, n_left;
    logic                        r_pend, n_pend;
    logic                        r_up, n_up;
    logic                        r_is_ins, n_is_ins;
    logic [ial_pkg::VALUE_W-1:0] r_rd, n_rd;
    ial_pkg::t_status            r_status, n_status;

    logic [EW-1:0] w_pos_e;
    logic [EW-1:0] w_cnt_e;
    logic [EW-1:0] w_cap_e;
    logic [EW-1:0] w_res_cnt;

    assign w_pos_e   = EW'(i_position);
    assign w_cnt_e   = EW'(r_count);
    assign w_cap_e   = EW'(CAPACITY);
    assign w_res_cnt = EW'(r_count);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ial_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // Working registers of the request in flight.
    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_pos    <= n_pos;
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_left   <= n_left;
        r_up     <= n_up;
        r_is_ins <= n_is_ins;
        r_rd     <= n_rd;
        r_status <= n_status;
    end

    // Decode, shift loop and result hand-off.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_value     = r_value;
        n_pos       = r_pos;
        n_src       = r_src;
        n_dst       = r_dst;
        n_left      = r_left;
        n_pend      = r_pend;
        n_up        = r_up;
        n_is_ins    = r_is_ins;
        n_rd        = r_rd;
        n_status    = r_status;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_dst;
        o_wr_data   = r_value;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_src;

        case (r_state)
            ial_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_value  = i_value;
                    n_rd     = '0;
                    n_status = ial_pkg::ST_OK;
                    n_pend   = 1'b0;
                    n_state  = ial_pkg::S_RESP;
                    case (ial_pkg::t_op'(i_op))
                        ial_pkg::OP_APPEND: begin
                            if (w_cnt_e >= w_cap_e) begin
                                n_status = ial_pkg::ST_FULL;
                            end else begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = AW'(r_count);
                                o_wr_data = i_value;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        ial_pkg::OP_INSERT: begin
                            if (w_pos_e < w_cnt_e) begin
                                if (w_cnt_e >= w_cap_e) begin
                                    n_status = ial_pkg::ST_FULL;
                                end else begin
                                    // Shift the tail up, top entry first.
                                    n_src    = AW'(w_cnt_e - EW'(1));
                                    n_dst    = AW'(r_count);
                                    n_left   = CW'(w_cnt_e - w_pos_e);
                                    n_pos    = AW'(i_position);
                                    n_up     = 1'b1;
                                    n_is_ins = 1'b1;
                                    n_state  = ial_pkg::S_MOVE;
                                end
                            end else if (w_pos_e >= w_cap_e) begin
                                n_status = ial_pkg::ST_FULL;
                            end else begin
                                // Fill from the old end through the position.
                                n_dst   = AW'(r_count);
                                n_pos   = AW'(i_position);
                                n_state = ial_pkg::S_FILL;
                            end
                        end
                        ial_pkg::OP_DELETE: begin
                            if (w_pos_e >= w_cnt_e) begin
                                n_status = ial_pkg::ST_OUTSIDE;
                            end else begin
                                // Shift the tail down, lowest entry first.
                                n_src    = AW'(w_pos_e + EW'(1));
                                n_dst    = AW'(i_position);
                                n_left   = CW'(w_cnt_e - w_pos_e - EW'(1));
                                n_up     = 1'b0;
                                n_is_ins = 1'b0;
                                n_state  = ial_pkg::S_MOVE;
                            end
                        end
                        ial_pkg::OP_READ: begin
                            if (w_pos_e >= w_cnt_e) begin
                                n_status = ial_pkg::ST_OUTSIDE;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(i_position);
                                n_state   = ial_pkg::S_RDWAIT;
                            end
                        end
                        ial_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            // Unused codes leave the list alone.
                        end
                    endcase
                end
            end

            ial_pkg::S_MOVE: begin
                // Write back the entry read last cycle.
                if (r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_dst;
                    o_wr_data = i_rd_data;
                    n_dst     = r_up ? (r_dst - AW'(1)) : (r_dst + AW'(1));
                end
                // Read the next source; it never lands on the entry being written.
                if (r_left != '0) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_src;
                    n_src     = r_up ? (r_src - AW'(1)) : (r_src + AW'(1));
                    n_left    = r_left - CW'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = ial_pkg::S_FINAL;
                    end
                end
            end

            ial_pkg::S_FINAL: begin
                if (r_is_ins) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_pos;
                    o_wr_data = r_value;
                    n_count   = r_count + CW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                end
                n_state = ial_pkg::S_RESP;
            end

            ial_pkg::S_FILL: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_dst;
                o_wr_data = r_value;
                n_dst     = r_dst + AW'(1);
                if (r_dst == r_pos) begin
                    n_count = CW'(r_pos) + CW'(1);
                    n_state = ial_pkg::S_RESP;
                end
            end

            ial_pkg::S_RDWAIT: begin
                n_rd    = i_rd_data;
                n_state = ial_pkg::S_RESP;
            end

            ial_pkg::S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ial_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ial_pkg::S_IDLE;
            end
        endcase
    end

    assign o_res.read_value = r_rd;
    assign o_res.count      = w_res_cnt[ial_pkg::COUNT_W-1:0];
    assign o_res.status     = r_status;

endmodule
